[sv/qrm_pkg.sv]
// qrm_pkg: widths, payload types and stage records for the quaternion to
// rotation matrix pipeline. No dependencies.
`default_nettype none
package qrm_pkg;

  localparam int FRAC_BITS = 14;
  localparam int IN_W      = 16;
  localparam int OUT_W     = FRAC_BITS + 2;
  localparam int QUOT_W    = FRAC_BITS + 1;
  localparam int PROD_W    = 2 * IN_W;
  localparam int NORM_W    = PROD_W + 1;
  localparam int NUM_W     = PROD_W + 2;
  localparam int MAG_W     = NORM_W;
  localparam int REM_W     = MAG_W + FRAC_BITS + 1;
  localparam int N_ENT     = 9;

  typedef struct packed {
    logic signed [IN_W-1:0] quat_w;
    logic signed [IN_W-1:0] quat_x;
    logic signed [IN_W-1:0] quat_y;
    logic signed [IN_W-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] c0r0;
    logic signed [OUT_W-1:0] c0r1;
    logic signed [OUT_W-1:0] c0r2;
    logic signed [OUT_W-1:0] c1r0;
    logic signed [OUT_W-1:0] c1r1;
    logic signed [OUT_W-1:0] c1r2;
    logic signed [OUT_W-1:0] c2r0;
    logic signed [OUT_W-1:0] c2r1;
    logic signed [OUT_W-1:0] c2r2;
    logic                    degenerate;
  } mat_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [QUOT_W-1:0] quot;
    logic              neg;
  } lane_t;

  typedef struct packed {
    logic [NORM_W-1:0]     norm;
    logic                  degen;
    lane_t [N_ENT-1:0]     lane;
  } div_t;

endpackage
`default_nettype wire

[sv/qrm_front.sv]
// qrm_front: products of the quaternion components, then squared norm,
// entry numerators and initial dividends. Depends on qrm_pkg.
`default_nettype none
module qrm_front
  import qrm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire logic  valid_i,
  input  wire quat_t data_i,
  output logic       valid_o,
  output div_t       data_o
);

  logic signed [PROD_W-1:0] ww_q, xx_q, yy_q, zz_q, xy_q, zw_q, xz_q, yw_q, yz_q, xw_q;
  logic                     v1_q, v2_q;
  div_t                     out_q;
  div_t                     out_d;

  function automatic logic signed [NUM_W-1:0] sx(input logic signed [PROD_W-1:0] p);
    sx = {{(NUM_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ww_q  <= data_i.quat_w * data_i.quat_w;
      xx_q  <= data_i.quat_x * data_i.quat_x;
      yy_q  <= data_i.quat_y * data_i.quat_y;
      zz_q  <= data_i.quat_z * data_i.quat_z;
      xy_q  <= data_i.quat_x * data_i.quat_y;
      zw_q  <= data_i.quat_z * data_i.quat_w;
      xz_q  <= data_i.quat_x * data_i.quat_z;
      yw_q  <= data_i.quat_y * data_i.quat_w;
      yz_q  <= data_i.quat_y * data_i.quat_z;
      xw_q  <= data_i.quat_x * data_i.quat_w;
      out_q <= out_d;
    end
  end

  always_comb begin
    logic [NORM_W-1:0]            n;
    logic signed [NUM_W-1:0]      nd;
    logic signed [NUM_W-1:0]      num [N_ENT];
    logic signed [NUM_W-1:0]      mag_s;
    logic [REM_W-1:0]             half;
    n = NORM_W'(ww_q[PROD_W-2:0]) + NORM_W'(xx_q[PROD_W-2:0])
      + NORM_W'(yy_q[PROD_W-2:0]) + NORM_W'(zz_q[PROD_W-2:0]);
    nd = $signed({1'b0, n});
    num[0] = nd - ((sx(yy_q) + sx(zz_q)) <<< 1);
    num[1] = (sx(xy_q) - sx(zw_q)) <<< 1;
    num[2] = (sx(xz_q) + sx(yw_q)) <<< 1;
    num[3] = (sx(xy_q) + sx(zw_q)) <<< 1;
    num[4] = nd - ((sx(xx_q) + sx(zz_q)) <<< 1);
    num[5] = (sx(yz_q) - sx(xw_q)) <<< 1;
    num[6] = (sx(xz_q) - sx(yw_q)) <<< 1;
    num[7] = (sx(yz_q) + sx(xw_q)) <<< 1;
    num[8] = nd - ((sx(xx_q) + sx(yy_q)) <<< 1);
    half = REM_W'(n >> 1);
    out_d.norm  = n;
    out_d.degen = (n == '0);
    for (int i = 0; i < N_ENT; i++) begin
      mag_s = num[i][NUM_W-1] ? -num[i] : num[i];
      out_d.lane[N_ENT-1-i].neg  = num[i][NUM_W-1];
      out_d.lane[N_ENT-1-i].quot = '0;
      out_d.lane[N_ENT-1-i].rem  =
        REM_W'({mag_s[MAG_W-1:0], {FRAC_BITS{1'b0}}}) + half;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = out_q;

endmodule
`default_nettype wire

[sv/qrm_divider.sv]
// qrm_divider: pipelined restoring division of nine dividends by the norm,
// one quotient bit per stage. Depends on qrm_pkg.
`default_nettype none
module qrm_divider
  import qrm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic valid_i,
  input  wire div_t data_i,
  output logic      valid_o,
  output div_t      data_o
);

  div_t              stage_q [QUOT_W];
  logic [QUOT_W-1:0] vld_q;

  for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
    localparam int Bit = QUOT_W - 1 - s;
    div_t prev;
    logic prev_v;
    div_t nxt;

    if (s == 0) begin : g_first
      assign prev   = data_i;
      assign prev_v = valid_i;
    end else begin : g_next
      assign prev   = stage_q[s-1];
      assign prev_v = vld_q[s-1];
    end

    always_comb begin
      logic [REM_W-1:0] dvs;
      logic             ge;
      nxt = prev;
      dvs = REM_W'(prev.norm) << Bit;
      for (int l = 0; l < N_ENT; l++) begin
        ge = prev.lane[l].rem >= dvs;
        nxt.lane[l].rem       = ge ? prev.lane[l].rem - dvs : prev.lane[l].rem;
        nxt.lane[l].quot[Bit] = ge;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[s] <= nxt;
      end
    end
  end

  assign valid_o = vld_q[QUOT_W-1];
  assign data_o  = stage_q[QUOT_W-1];

endmodule
`default_nettype wire

[sv/quaternion_to_rotation_matrix.sv]
// quaternion_to_rotation_matrix: top level, front products, divider pipeline
// and saturating output register. Depends on qrm_pkg, qrm_front, qrm_divider.
//
//   channel  valid        stall        payload
//   in       in_valid_i   in_stall_o   in_data_i  (quat_t)
//   out      out_valid_o  out_stall_i  out_data_o (mat_t)
//
// One transaction per cycle unless the output stalls; two front stages,
// fifteen divider stages (one quotient bit each), one output register.
// Reset clears all valid bits; payload registers are not reset.
// A stalled output with a valid result freezes the whole pipeline.
`default_nettype none
module quaternion_to_rotation_matrix
  import qrm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire quat_t in_data_i,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output mat_t       out_data_o
);

  localparam logic [QUOT_W-1:0] One = QUOT_W'(1) << FRAC_BITS;

  logic en;
  logic fr_valid, dv_valid;
  div_t fr_data, dv_data;
  logic out_valid_q;
  mat_t out_data_q, out_data_d;

  assign en = !out_valid_q || !out_stall_i;

  qrm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (fr_valid),
    .data_o  (fr_data)
  );

  qrm_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .data_i  (fr_data),
    .valid_o (dv_valid),
    .data_o  (dv_data)
  );

  always_comb begin
    logic [OUT_W-1:0] ent [N_ENT];
    logic [QUOT_W-1:0] q;
    for (int i = 0; i < N_ENT; i++) begin
      q = dv_data.lane[N_ENT-1-i].quot;
      if (q > One) begin
        q = One;
      end
      ent[i] = dv_data.lane[N_ENT-1-i].neg ? -OUT_W'(q) : OUT_W'(q);
    end
    if (dv_data.degen) begin
      for (int i = 0; i < N_ENT; i++) begin
        ent[i] = '0;
      end
      ent[0] = OUT_W'(One);
      ent[4] = OUT_W'(One);
      ent[8] = OUT_W'(One);
    end
    out_data_d.c0r0       = ent[0];
    out_data_d.c0r1       = ent[1];
    out_data_d.c0r2       = ent[2];
    out_data_d.c1r0       = ent[3];
    out_data_d.c1r1       = ent[4];
    out_data_d.c1r2       = ent[5];
    out_data_d.c2r0       = ent[6];
    out_data_d.c2r1       = ent[7];
    out_data_d.c2r2       = ent[8];
    out_data_d.degenerate = dv_data.degen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
    end
  end

  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

[bench/tb.sv]
// tb: self-checking bench for quaternion_to_rotation_matrix. Predicts each
// rotation matrix from the quaternion and checks results in order.
// Depends on qrm_pkg and the quaternion_to_rotation_matrix RTL.
`default_nettype none
module tb;
  import qrm_pkg::*;

  localparam int       NUM_RANDOM = 1100;
  localparam int       LATENCY    = 18;
  localparam longint   CYCLE_CAP  = 400000;
  localparam bit [1:0] MODE_RAND  = 2'd0;
  localparam bit [1:0] MODE_UNIT  = 2'd1;
  localparam bit [1:0] MODE_SMALL = 2'd2;
  localparam bit [1:0] MODE_EDGE  = 2'd3;

  class matrix_scoreboard;
    mat_t expected_q[$];
    int   mismatches;
    int   unexpected;

    function automatic logic signed [OUT_W-1:0] entry(longint num, longint norm);
      longint one;
      longint mag;
      longint q;
      one = longint'(1) << FRAC_BITS;
      mag = (num < 0) ? -num : num;
      q = ((mag << FRAC_BITS) + norm / 2) / norm;
      if (q > one) q = one;
      return (num < 0) ? OUT_W'(-q) : OUT_W'(q);
    endfunction

    function void note_quat(quat_t qt);
      longint w, x, y, z, ww, xx, yy, zz, n;
      mat_t m;
      w = qt.quat_w; x = qt.quat_x; y = qt.quat_y; z = qt.quat_z;
      ww = w * w; xx = x * x; yy = y * y; zz = z * z;
      n = ww + xx + yy + zz;
      m = '0;
      if (n == 0) begin
        m.c0r0 = OUT_W'(1 << FRAC_BITS);
        m.c1r1 = OUT_W'(1 << FRAC_BITS);
        m.c2r2 = OUT_W'(1 << FRAC_BITS);
        m.degenerate = 1'b1;
      end else begin
        m.c0r0 = entry(n - 2 * (yy + zz), n);
        m.c0r1 = entry(2 * (x * y - z * w), n);
        m.c0r2 = entry(2 * (x * z + y * w), n);
        m.c1r0 = entry(2 * (x * y + z * w), n);
        m.c1r1 = entry(n - 2 * (xx + zz), n);
        m.c1r2 = entry(2 * (y * z - x * w), n);
        m.c2r0 = entry(2 * (x * z - y * w), n);
        m.c2r1 = entry(2 * (y * z + x * w), n);
        m.c2r2 = entry(n - 2 * (xx + yy), n);
      end
      expected_q.push_back(m);
    endfunction

    function void check_matrix(mat_t got);
      mat_t exp_m;
      if (expected_q.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_m = expected_q.pop_front();
      if (got !== exp_m) begin
        mismatches++;
        if (mismatches + unexpected <= 10) begin
          $display("mismatch c0: exp %0d %0d %0d got %0d %0d %0d",
                   exp_m.c0r0, exp_m.c0r1, exp_m.c0r2, got.c0r0, got.c0r1, got.c0r2);
          $display("mismatch c1: exp %0d %0d %0d got %0d %0d %0d",
                   exp_m.c1r0, exp_m.c1r1, exp_m.c1r2, got.c1r0, got.c1r1, got.c1r2);
          $display("mismatch c2: exp %0d %0d %0d got %0d %0d %0d degen exp %b got %b",
                   exp_m.c2r0, exp_m.c2r1, exp_m.c2r2, got.c2r0, got.c2r1, got.c2r2,
                   exp_m.degenerate, got.degenerate);
        end
      end
    endfunction
  endclass

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  quat_t in_data_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  mat_t  out_data_o;

  matrix_scoreboard board = new();
  longint cycle_count = 0;
  bit     sender_calm = 1'b0;
  bit     receiver_calm = 1'b0;
  bit     hold_off = 1'b0;

  quaternion_to_rotation_matrix dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.note_quat(in_data_i);
      if (out_valid_o && !out_stall_i) board.check_matrix(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else if (receiver_calm) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < 20);
  end

  task automatic send_quat(quat_t qt);
    if (!sender_calm) begin
      while ($urandom_range(99) < 20) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i <= qt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_four(int w, int x, int y, int z);
    quat_t qt;
    qt.quat_w = IN_W'(w); qt.quat_x = IN_W'(x);
    qt.quat_y = IN_W'(y); qt.quat_z = IN_W'(z);
    send_quat(qt);
  endtask

  function automatic logic [IN_W-1:0] pick_comp(bit [1:0] mode);
    case (mode)
      MODE_UNIT:  return IN_W'($urandom_range(32768) - 16384);
      MODE_SMALL: return IN_W'($urandom_range(6) - 3);
      MODE_EDGE: begin
        case ($urandom_range(4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'hffff;
          default: return 16'h4000;
        endcase
      end
      default: return IN_W'($urandom);
    endcase
  endfunction

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.expected_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    quat_t qt;
    bit [1:0] mode;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_four(0, 0, 0, 0);
    send_four(16384, 0, 0, 0);
    send_four(0, 16384, 0, 0);
    send_four(0, 0, 16384, 0);
    send_four(0, 0, 0, 16384);
    send_four(-32768, -32768, -32768, -32768);
    send_four(32767, 32767, 32767, 32767);
    send_four(-32768, 0, 0, 0);
    send_four(0, -32768, 32767, 0);
    send_four(1, 0, 0, 0);
    send_four(0, 0, 0, -1);
    send_four(1, 1, 0, 0);
    send_four(1, 1, 1, 1);
    send_four(11585, 11585, 0, 0);
    send_four(8192, -8192, 8192, -8192);
    send_four(-1, 2, -3, 4);
    send_four(32767, -32768, 1, -1);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 200) begin
        drain_pipe();
        sender_calm = 1'b1;
        receiver_calm = 1'b1;
      end
      if (i == 400) begin
        sender_calm = 1'b0;
        receiver_calm = 1'b0;
      end
      if (i == 500) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (120) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      if (i == 800) drain_pipe();
      mode = 2'($urandom_range(3));
      qt.quat_w = pick_comp(mode);
      qt.quat_x = pick_comp(mode);
      qt.quat_y = pick_comp(mode);
      qt.quat_z = pick_comp(mode);
      send_quat(qt);
    end
    in_valid_i <= 1'b0;
    hold_off = 1'b0;
    @(posedge clk_i);
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (board.mismatches == 0 && board.unexpected == 0 && board.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
